@@ hw/rtl/cts_pkg.sv @@
// Shared types and constants for the cooperative task scheduler.
package cts_pkg;

	localparam int SLOT_COUNT = 16;
	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);

	localparam int TAG_W = 16;
	localparam int DLY_W = 16;
	localparam int PER_W = 16;
	localparam int PEND_W = 8;

	typedef enum logic [1:0] {
		MODE_ADD  = 2'd0,
		MODE_DEL  = 2'd1,
		MODE_TICK = 2'd2,
		MODE_DISP = 2'd3
	} mode_t;

	localparam logic [1:0] KIND_ADD  = 2'd0;
	localparam logic [1:0] KIND_DEL  = 2'd1;
	localparam logic [1:0] KIND_DISP = 2'd2;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_FULL      = 2'd1;
	localparam logic [1:0] ERR_EMPTY_DEL = 2'd2;

	// One slot of the task table as it sits in memory.
	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [DLY_W-1:0]  delay;
		logic [PER_W-1:0]  period;
		logic [PEND_W-1:0] pending;
	} slot_entry_t;

	// Write port of the slot memory.
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		slot_entry_t      data;
	} mem_wr_t;

endpackage

@@ hw/rtl/cts_slot_mem.sv @@
// Slot table memory: one write port, one registered read port.
module cts_slot_mem (
	input  logic                         clk,
	input  cts_pkg::mem_wr_t             wr,
	input  logic                         rd_en,
	input  logic [cts_pkg::IDX_W-1:0]    rd_addr,
	output cts_pkg::slot_entry_t         rd_data
);
	import cts_pkg::*;

	slot_entry_t mem_q [SLOT_COUNT];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ hw/rtl/cooperative_task_scheduler.sv @@
// Top level of the cooperative task scheduler: command decode, slot sweeps and result words.
//
//   channel   signals                                          direction  handshake
//   command   start, busy, mode, task_tag, start_delay,         in         start & !busy
//             repeat_period, slot_index
//   result    strobe, kind, slot, run_tag, status,             out        strobe, one cycle
//             error_code, last
//
// Add and delete are decoded in the cycle the command word is taken; their single result
// word appears on the following cycle and busy never rises, so commands of this kind can
// follow each other every cycle. Tick and dispatch sweep the slot memory one slot per
// cycle through the registered read port, and busy stays high for the whole sweep.
// A dispatch with nothing due answers straight from the idle state without a sweep. The result
// side cannot stall; each word is valid for exactly the one cycle that strobe is high.
// Reset clears the occupancy and due flags and the sticky error, so the memory itself
// needs no clearing pass: a free slot always reads as empty.
module cooperative_task_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [15:0] task_tag,
	input  logic [15:0] start_delay,
	input  logic [15:0] repeat_period,
	input  logic [3:0]  slot_index,
	output logic        strobe,
	output logic [1:0]  kind,
	output logic [4:0]  slot,
	output logic [15:0] run_tag,
	output logic        status,
	output logic [1:0]  error_code,
	output logic        last
);
	import cts_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_DISP
	} state_t;

	state_t state_q;

	// A slot is occupied from an add with a nonzero tag until it is freed; it is due while it holds pending runs.
	// Both flags live in flip-flops so that searches and "last" need no memory read.
	logic [SLOT_COUNT-1:0] occ_q;
	logic [SLOT_COUNT-1:0] due_q;
	logic [1:0]            err_q;

	// Sweep pipeline: the read counter issues addresses, stage 1 holds the slot whose
	// data is coming out of the memory this cycle.
	logic [CNT_W-1:0] rd_cnt_q;
	logic             valid_s1;
	logic [IDX_W-1:0] idx_s1;

	logic        strobe_q;
	logic [1:0]  kind_q;
	logic [4:0]  slot_q;
	logic [15:0] run_tag_q;
	logic        status_q;
	logic        last_q;

	logic        accept;
	mode_t       cmd_mode;
	logic        free_found;
	logic [IDX_W-1:0] free_idx;
	logic        del_in_range;
	logic [IDX_W-1:0] del_idx;
	logic        rd_en;
	logic [IDX_W-1:0] rd_addr;
	slot_entry_t rd_data;
	mem_wr_t     mem_wr;
	logic        sweep_more;
	logic        hi_due;

	// Stage 1 update results.
	logic        tick_hit;
	logic        disp_hit;
	slot_entry_t upd_entry;
	logic        upd_due;
	logic        disp_free;

	assign accept   = start && !busy;
	assign cmd_mode = mode_t'(mode);
	assign busy     = (state_q != ST_IDLE);

	// Lowest free slot.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!occ_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	assign del_in_range = (32'(slot_index) < 32'(SLOT_COUNT));
	assign del_idx      = IDX_W'(slot_index);

	// Sweep read side.
	assign sweep_more = (rd_cnt_q < CNT_W'(SLOT_COUNT));
	assign rd_en      = (state_q != ST_IDLE) && sweep_more;
	assign rd_addr    = rd_cnt_q[IDX_W-1:0];

	cts_slot_mem u_mem (
		.clk     (clk),
		.wr      (mem_wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Any slot above the one in stage 1 still due? Slots above it are untouched so far.
	always_comb begin
		hi_due = 1'b0;
		for (int j = 0; j < SLOT_COUNT; j++) begin
			if ((IDX_W'(j) > idx_s1) && due_q[j]) begin
				hi_due = 1'b1;
			end
		end
	end

	// Per-slot update in stage 1.
	always_comb begin
		tick_hit  = (state_q == ST_TICK) && valid_s1 && occ_q[idx_s1];
		disp_hit  = (state_q == ST_DISP) && valid_s1 && due_q[idx_s1];
		upd_entry = rd_data;
		upd_due   = 1'b0;
		disp_free = 1'b0;
		if (state_q == ST_TICK) begin
			if (rd_data.delay == '0) begin
				if (rd_data.pending != {PEND_W{1'b1}}) begin
					upd_entry.pending = rd_data.pending + PEND_W'(1);
				end
				if (rd_data.period != '0) begin
					upd_entry.delay = rd_data.period;
				end
			end else begin
				upd_entry.delay = rd_data.delay - DLY_W'(1);
			end
		end else begin
			upd_entry.pending = rd_data.pending - PEND_W'(1);
			// A one-shot task leaves the table once it has run.
			disp_free = (rd_data.period == '0);
		end
		upd_due = (upd_entry.pending != '0) && !disp_free;
	end

	// Memory write port: an add in the idle state, or the write-back of a sweep.
	always_comb begin
		mem_wr.en   = 1'b0;
		mem_wr.addr = idx_s1;
		mem_wr.data = upd_entry;
		if (accept && (cmd_mode == MODE_ADD)) begin
			mem_wr.en           = free_found;
			mem_wr.addr         = free_idx;
			mem_wr.data.tag     = task_tag;
			mem_wr.data.delay   = start_delay;
			mem_wr.data.period  = repeat_period;
			mem_wr.data.pending = '0;
		end else if (tick_hit || (disp_hit && !disp_free)) begin
			mem_wr.en = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			occ_q     <= '0;
			due_q     <= '0;
			err_q     <= ERR_NONE;
			rd_cnt_q  <= '0;
			valid_s1  <= 1'b0;
			idx_s1    <= '0;
			strobe_q  <= 1'b0;
			kind_q    <= KIND_ADD;
			slot_q    <= '0;
			run_tag_q <= '0;
			status_q  <= 1'b0;
			last_q    <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (cmd_mode)
							MODE_ADD: begin
								strobe_q  <= 1'b1;
								kind_q    <= KIND_ADD;
								run_tag_q <= '0;
								status_q  <= 1'b0;
								last_q    <= 1'b1;
								if (free_found) begin
									slot_q <= 5'(free_idx);
									// A zero tag leaves the slot free.
									occ_q[free_idx] <= (task_tag != '0);
									due_q[free_idx] <= 1'b0;
								end else begin
									slot_q <= 5'(SLOT_COUNT);
									err_q  <= ERR_FULL;
								end
							end
							MODE_DEL: begin
								strobe_q  <= 1'b1;
								kind_q    <= KIND_DEL;
								slot_q    <= 5'(slot_index);
								run_tag_q <= '0;
								last_q    <= 1'b1;
								if (del_in_range) begin
									status_q <= !occ_q[del_idx];
									if (!occ_q[del_idx]) begin
										err_q <= ERR_EMPTY_DEL;
									end
									occ_q[del_idx] <= 1'b0;
									due_q[del_idx] <= 1'b0;
								end else begin
									// Out-of-range slot counts as empty.
									status_q <= 1'b1;
									err_q    <= ERR_EMPTY_DEL;
								end
							end
							MODE_TICK: begin
								state_q  <= ST_TICK;
								rd_cnt_q <= '0;
								valid_s1 <= 1'b0;
							end
							MODE_DISP: begin
								if (due_q == '0) begin
									strobe_q  <= 1'b1;
									kind_q    <= KIND_DISP;
									slot_q    <= '0;
									run_tag_q <= '0;
									status_q  <= 1'b1;
									last_q    <= 1'b1;
								end else begin
									state_q  <= ST_DISP;
									rd_cnt_q <= '0;
									valid_s1 <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_TICK, ST_DISP: begin
					// Issue the next read while stage 1 writes back the previous slot.
					valid_s1 <= sweep_more;
					idx_s1   <= rd_addr;
					if (sweep_more) begin
						rd_cnt_q <= rd_cnt_q + CNT_W'(1);
					end
					if (tick_hit) begin
						due_q[idx_s1] <= upd_due;
					end
					if (disp_hit) begin
						due_q[idx_s1] <= upd_due;
						if (disp_free) begin
							occ_q[idx_s1] <= 1'b0;
						end
						strobe_q  <= 1'b1;
						kind_q    <= KIND_DISP;
						slot_q    <= 5'(idx_s1);
						run_tag_q <= rd_data.tag;
						status_q  <= 1'b0;
						last_q    <= !hi_due;
					end
					if (!sweep_more && valid_s1) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe     = strobe_q;
	assign kind       = kind_q;
	assign slot       = slot_q;
	assign run_tag    = run_tag_q;
	assign status     = status_q;
	assign error_code = err_q;
	assign last       = last_q;

endmodule
